// ----- sv/psd_pkg.sv -----
package psd_pkg;

  localparam int POS_W          = 19;
  localparam int PKT_BYTES_W    = 16;
  localparam int OFS_BITS_W     = 5;
  localparam int HLEN_W         = 6;
  localparam int FFO_W          = 24;
  localparam int CFG_DATA_W     = 16;

  localparam logic [PKT_BYTES_W-1:0] PKT_BYTES_RST  = 16'd2048;
  localparam logic [PKT_BYTES_W-1:0] PKT_BYTES_MIN  = 16'd5;
  localparam logic [OFS_BITS_W-1:0]  OFS_BITS_RST   = 5'd11;
  localparam logic [HLEN_W-1:0]      HDR_FIXED_BITS = 6'd8;
  localparam logic [OFS_BITS_W-1:0]  SEQ_FIELD_SKIP = 5'd4;

  typedef enum logic [0:0] {
    REG_PACKET_BYTES = 1'b0,
    REG_OFFSET_BITS  = 1'b1
  } psd_reg_e;

  typedef struct packed {
    logic [7:0]       payload_bits;
    logic [3:0]       payload_count;
    logic             header_done;
    logic [POS_W-1:0] pos_next;
  } psd_lane_t;

  typedef struct packed {
    logic [7:0]       payload_bits;
    logic [3:0]       payload_count;
    logic             header_done;
    logic [3:0]       seq_number;
    logic [3:0]       frames_in_packet;
    logic [FFO_W-1:0] first_frame_offset;
    logic             seq_error;
  } psd_res_t;

  typedef struct packed {
    logic [3:0]       seq_number;
    logic [3:0]       frames_in_packet;
    logic [FFO_W-1:0] first_frame_offset;
    logic             seq_error;
  } psd_hdr_t;

endpackage

// ----- sv/psd_if.sv -----
interface psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       restart;

  modport source (output valid, raw_byte, restart, input ready);
  modport sink (input valid, raw_byte, restart, output ready);
endinterface

interface psd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_bits;
  logic [3:0]  payload_count;
  logic        header_done;
  logic [3:0]  seq_number;
  logic [3:0]  frames_in_packet;
  logic [23:0] first_frame_offset;
  logic        seq_error;

  modport source (
    output valid, payload_bits, payload_count, header_done, seq_number,
           frames_in_packet, first_frame_offset, seq_error,
    input  ready
  );
  modport sink (
    input  valid, payload_bits, payload_count, header_done, seq_number,
           frames_in_packet, first_frame_offset, seq_error,
    output ready
  );
endinterface

// ----- sv/packet_header_strip_deframer_top.sv -----
// Channel  Dir  Payload                                              Accept
// in_i     in   raw_byte[7:0], restart                               valid & ready
// out_o    out  payload_bits[7:0], payload_count[3:0], header_done,  valid & ready
//               seq_number[3:0], frames_in_packet[3:0],
//               first_frame_offset[23:0], seq_error
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i[15:0]                cfg_we_i
//
// One transaction per cycle sustained while out_o is ready; each byte passes
// from input to output through the input register, then the result register.
// The per-byte bit-lane logic and header decode sit between the two registers.
// Reset clears position, header shift, sequence history and both valid flags.
// A stalled output holds its result; the input register still fills behind it.
module packet_header_strip_deframer_top import psd_pkg::*; #(
  parameter int MAX_OFFSET_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  psd_in_if.sink                in_i,
  psd_out_if.source             out_o
);

  localparam int HDR_W = 8 + MAX_OFFSET_BITS;

  logic [PKT_BYTES_W-1:0] pkt_bytes_q, pkt_bytes_d;
  logic [OFS_BITS_W-1:0]  ofs_bits_q, ofs_bits_d;

  logic                   s1_valid_q, s1_valid_d;
  logic [7:0]             s1_byte_q;
  logic                   s1_restart_q;
  logic                   out_valid_q, out_valid_d;
  psd_res_t               res_q, res_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [HDR_W-1:0]       shift_q, shift_d;

  logic                   in_fire;
  logic                   s1_adv;
  logic [PKT_BYTES_W-1:0] pbytes;
  logic [POS_W-1:0]       plen;
  logic [OFS_BITS_W-1:0]  obits;
  logic [HLEN_W-1:0]      hlen;
  logic [POS_W-1:0]       pos_eff;
  logic [HDR_W-1:0]       shift_eff;
  psd_lane_t              lane;
  logic [HDR_W-1:0]       lane_shift;
  logic [HDR_W-1:0]       lane_hdr;
  psd_hdr_t               hdr;

  always_comb begin
    pkt_bytes_d = pkt_bytes_q;
    ofs_bits_d  = ofs_bits_q;
    if (cfg_we_i) begin
      unique case (psd_reg_e'(cfg_idx_i))
        REG_PACKET_BYTES: pkt_bytes_d = cfg_data_i[PKT_BYTES_W-1:0];
        REG_OFFSET_BITS:  ofs_bits_d  = cfg_data_i[OFS_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pbytes = (pkt_bytes_q < PKT_BYTES_MIN) ? PKT_BYTES_MIN : pkt_bytes_q;
  assign plen   = {pbytes, 3'b000};
  assign obits  = (ofs_bits_q > OFS_BITS_W'(MAX_OFFSET_BITS)) ?
                  OFS_BITS_W'(MAX_OFFSET_BITS) : ofs_bits_q;
  assign hlen   = HDR_FIXED_BITS + HLEN_W'(obits);

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  // clear stream state ahead of a restart byte
  assign pos_eff   = s1_restart_q ? '0 : pos_q;
  assign shift_eff = s1_restart_q ? '0 : shift_q;

  psd_lanes #(
    .HDR_W (HDR_W)
  ) u_lanes (
    .raw_byte_i (s1_byte_q),
    .pos_i      (pos_eff),
    .plen_i     (plen),
    .hlen_i     (hlen),
    .shift_i    (shift_eff),
    .lane_o     (lane),
    .shift_o    (lane_shift),
    .hdr_o      (lane_hdr)
  );

  psd_hdr_dec #(
    .HDR_W           (HDR_W),
    .MAX_OFFSET_BITS (MAX_OFFSET_BITS)
  ) u_hdr_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_adv),
    .restart_i (s1_restart_q),
    .done_i    (lane.header_done),
    .hdr_i     (lane_hdr),
    .obits_i   (obits),
    .hdr_o     (hdr)
  );

  always_comb begin
    pos_d   = pos_q;
    shift_d = shift_q;
    res_d   = res_q;
    if (s1_adv) begin
      pos_d                    = lane.pos_next;
      shift_d                  = lane_shift;
      res_d.payload_bits       = lane.payload_bits;
      res_d.payload_count      = lane.payload_count;
      res_d.header_done        = lane.header_done;
      res_d.seq_number         = hdr.seq_number;
      res_d.frames_in_packet   = hdr.frames_in_packet;
      res_d.first_frame_offset = hdr.first_frame_offset;
      res_d.seq_error          = hdr.seq_error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_bytes_q <= PKT_BYTES_RST;
      ofs_bits_q  <= OFS_BITS_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      shift_q     <= '0;
    end else begin
      pkt_bytes_q <= pkt_bytes_d;
      ofs_bits_q  <= ofs_bits_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      shift_q     <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q    <= in_i.raw_byte;
      s1_restart_q <= in_i.restart;
    end
    res_q <= res_d;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.payload_bits       = res_q.payload_bits;
  assign out_o.payload_count      = res_q.payload_count;
  assign out_o.header_done        = res_q.header_done;
  assign out_o.seq_number         = res_q.seq_number;
  assign out_o.frames_in_packet   = res_q.frames_in_packet;
  assign out_o.first_frame_offset = res_q.first_frame_offset;
  assign out_o.seq_error          = res_q.seq_error;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.payload_count <= 4'd8))
    else $error("payload count above eight");

  a_unused_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.payload_bits >> res_q.payload_count) == 8'd0))
    else $error("payload bits above count not zero");

  a_no_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.header_done) |->
      (res_q.seq_number == 4'd0 && res_q.frames_in_packet == 4'd0 &&
       res_q.first_frame_offset == '0 && !res_q.seq_error))
    else $error("header fields set without header completion");

  a_header_payload_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.header_done) |-> (res_q.payload_count != 4'd8))
    else $error("header completed on a byte with all payload bits");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s1_adv) |-> (pos_q <= $past(plen)))
    else $error("bit position past packet length");

endmodule

// ----- sv/psd_lanes.sv -----
module psd_lanes import psd_pkg::*; #(
  parameter int HDR_W = 32
) (
  input  logic [7:0]        raw_byte_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic [POS_W-1:0]  plen_i,
  input  logic [HLEN_W-1:0] hlen_i,
  input  logic [HDR_W-1:0]  shift_i,
  output psd_lane_t         lane_o,
  output logic [HDR_W-1:0]  shift_o,
  output logic [HDR_W-1:0]  hdr_o
);

  logic [POS_W-1:0] p0;
  logic [POS_W-1:0] rem_bits;
  logic [POS_W-1:0] hlen_ext;

  assign p0       = (pos_i >= plen_i) ? '0 : pos_i;
  assign rem_bits = plen_i - p0;
  assign hlen_ext = POS_W'(hlen_i);

  always_comb begin
    logic [POS_W-1:0] pk;
    logic [HDR_W-1:0] sh;
    logic [HDR_W-1:0] hdr;
    logic [7:0]       pl;
    logic [3:0]       cnt;
    logic             done;
    logic             bitv;
    pk   = '0;
    sh   = shift_i;
    hdr  = '0;
    pl   = '0;
    cnt  = '0;
    done = 1'b0;
    bitv = 1'b0;
    for (int k = 0; k < 8; k++) begin
      bitv = raw_byte_i[7-k];
      if (rem_bits <= POS_W'(k)) begin
        pk = POS_W'(k) - rem_bits;
      end else begin
        pk = p0 + POS_W'(k);
      end
      if (pk == '0) begin
        sh = '0;
      end
      if (pk < hlen_ext) begin
        sh = {sh[HDR_W-2:0], bitv};
        if ((pk + POS_W'(1)) == hlen_ext) begin
          done = 1'b1;
          hdr  = sh;
        end
      end else begin
        pl  = {pl[6:0], bitv};
        cnt = cnt + 4'd1;
      end
    end
    lane_o.payload_bits  = pl;
    lane_o.payload_count = cnt;
    lane_o.header_done   = done;
    lane_o.pos_next      = pk + POS_W'(1);
    shift_o              = sh;
    hdr_o                = hdr;
  end

endmodule

// ----- sv/psd_hdr_dec.sv -----
module psd_hdr_dec import psd_pkg::*; #(
  parameter int HDR_W           = 32,
  parameter int MAX_OFFSET_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  restart_i,
  input  logic                  done_i,
  input  logic [HDR_W-1:0]      hdr_i,
  input  logic [OFS_BITS_W-1:0] obits_i,
  output psd_hdr_t              hdr_o
);

  logic [3:0]            prev_seq_q, prev_seq_d;
  logic                  have_prev_q, have_prev_d;
  logic [3:0]            prev_eff;
  logic                  have_eff;
  logic [OFS_BITS_W-1:0] seq_shift;
  logic [HDR_W-1:0]      ffo_mask;
  logic [HDR_W-1:0]      ffo_full;
  logic [3:0]            seq;
  logic [3:0]            frames;

  assign prev_eff  = restart_i ? 4'd0 : prev_seq_q;
  assign have_eff  = restart_i ? 1'b0 : have_prev_q;
  assign seq_shift = obits_i + SEQ_FIELD_SKIP;
  assign seq       = 4'(hdr_i >> seq_shift);
  assign frames    = 4'(hdr_i >> obits_i);
  assign ffo_mask  = ~({HDR_W{1'b1}} << obits_i);
  assign ffo_full  = hdr_i & ffo_mask;

  always_comb begin
    hdr_o = '0;
    if (done_i) begin
      hdr_o.seq_number         = seq;
      hdr_o.frames_in_packet   = frames;
      hdr_o.first_frame_offset = FFO_W'(ffo_full[MAX_OFFSET_BITS-1:0]);
      hdr_o.seq_error          = have_eff && (seq != (prev_eff + 4'd1));
    end
  end

  always_comb begin
    prev_seq_d  = prev_seq_q;
    have_prev_d = have_prev_q;
    if (en_i) begin
      if (done_i) begin
        prev_seq_d  = seq;
        have_prev_d = 1'b1;
      end else begin
        prev_seq_d  = prev_eff;
        have_prev_d = have_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_seq_q  <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_seq_q  <= prev_seq_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

// ----- tb/psd_checker.sv -----
module psd_checker import psd_pkg::*; #(
  parameter int MAX_OFFSET_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  psd_in_if                     in_mon_i,
  psd_out_if                    out_mon_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [PKT_BYTES_W-1:0] pkt_bytes;
  logic [OFS_BITS_W-1:0]  ofs_bits;
  logic [POS_W-1:0]       bit_pos;
  logic [31:0]            hdr_bits;
  logic [3:0]             last_seq;
  logic                   seen_hdr;
  psd_res_t               results_due[$];
  int                     mismatches;

  task automatic deframe_byte(input logic [7:0] b, input logic rs, output psd_res_t r);
    int unsigned plen;
    int unsigned hlen;
    int unsigned obits;
    int          i;
    r     = '0;
    obits = (ofs_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : ofs_bits;
    plen  = 8 * ((pkt_bytes < PKT_BYTES_MIN) ? PKT_BYTES_MIN : pkt_bytes);
    hlen  = HDR_FIXED_BITS + obits;
    if (rs) begin
      bit_pos  = '0;
      hdr_bits = '0;
      last_seq = '0;
      seen_hdr = 1'b0;
    end
    for (i = 7; i >= 0; i--) begin
      if (bit_pos >= plen) begin
        bit_pos  = '0;
        hdr_bits = '0;
      end
      if (bit_pos < hlen) begin
        hdr_bits = {hdr_bits[30:0], b[i]};
        if (bit_pos + 1 == hlen) begin
          r.header_done        = 1'b1;
          r.seq_number         = 4'(hdr_bits >> (obits + 4));
          r.frames_in_packet   = 4'(hdr_bits >> obits);
          r.first_frame_offset = 24'(hdr_bits & ((33'd1 << obits) - 1));
          r.seq_error          = seen_hdr && (r.seq_number != 4'(last_seq + 4'd1));
          last_seq             = r.seq_number;
          seen_hdr             = 1'b1;
        end
      end else begin
        r.payload_bits  = {r.payload_bits[6:0], b[i]};
        r.payload_count = r.payload_count + 4'd1;
      end
      bit_pos = bit_pos + 1'b1;
    end
  endtask

  task automatic flag(input string what, input longint unsigned want,
                      input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    psd_res_t want;
    if (!rst_ni) begin
      pkt_bytes  = PKT_BYTES_RST;
      ofs_bits   = OFS_BITS_RST;
      bit_pos    = '0;
      hdr_bits   = '0;
      last_seq   = '0;
      seen_hdr   = 1'b0;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PACKET_BYTES) begin
          pkt_bytes = cfg_data_i;
        end else begin
          ofs_bits = cfg_data_i[OFS_BITS_W-1:0];
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result with no transaction pending: payload %0h count %0d header %0b",
                     out_mon_i.payload_bits, out_mon_i.payload_count,
                     out_mon_i.header_done);
          end
        end else begin
          want = results_due.pop_front();
          if (out_mon_i.payload_bits !== want.payload_bits)
            flag("payload_bits", want.payload_bits, out_mon_i.payload_bits);
          if (out_mon_i.payload_count !== want.payload_count)
            flag("payload_count", want.payload_count, out_mon_i.payload_count);
          if (out_mon_i.header_done !== want.header_done)
            flag("header_done", want.header_done, out_mon_i.header_done);
          if (out_mon_i.seq_number !== want.seq_number)
            flag("seq_number", want.seq_number, out_mon_i.seq_number);
          if (out_mon_i.frames_in_packet !== want.frames_in_packet)
            flag("frames_in_packet", want.frames_in_packet, out_mon_i.frames_in_packet);
          if (out_mon_i.first_frame_offset !== want.first_frame_offset)
            flag("first_frame_offset", want.first_frame_offset,
                 out_mon_i.first_frame_offset);
          if (out_mon_i.seq_error !== want.seq_error)
            flag("seq_error", want.seq_error, out_mon_i.seq_error);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        deframe_byte(in_mon_i.raw_byte, in_mon_i.restart, want);
        results_due.push_back(want);
      end
    end
    fail_count_o = mismatches;
    pending_o    = results_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import psd_pkg::*;

  localparam int MAX_OFS     = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [0:0]            cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycles;
  int                    sent;
  bit                    idle_on;

  int unsigned           gen_pos;
  logic [31:0]           gen_hdr;
  logic [3:0]            gen_seq;

  psd_in_if  in_if ();
  psd_out_if out_if ();

  packet_header_strip_deframer_top #(
    .MAX_OFFSET_BITS(MAX_OFS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  psd_checker #(
    .MAX_OFFSET_BITS(MAX_OFS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= !idle_on || ($urandom_range(99) >= 30);
  end

  task automatic push_byte(input logic [7:0] b, input logic rs);
    while (idle_on && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.raw_byte <= b;
    in_if.restart  <= rs;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    @(negedge clk_i);
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(input int unsigned pb, input int unsigned ob);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_PACKET_BYTES;
    cfg_data <= CFG_DATA_W'(pb);
    @(negedge clk_i);
    cfg_idx  <= REG_OFFSET_BITS;
    cfg_data <= CFG_DATA_W'(ob);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_phase();
    int unsigned pb;
    int unsigned ob;
    int unsigned plen;
    int unsigned hlen;
    int unsigned n;
    int unsigned k;
    logic [3:0]  seq;
    logic [7:0]  b;
    logic        rs;
    bit          noise;
    case ($urandom_range(19))
      0:       pb = $urandom_range(4);
      1:       pb = 16'hFFFF;
      2:       pb = $urandom_range(13, 2000);
      default: pb = $urandom_range(5, 12);
    endcase
    ob = ($urandom_range(9) == 0) ? $urandom_range(25, 31) : $urandom_range(MAX_OFS);
    drain();
    write_config(pb, ob);
    plen  = 8 * ((pb < 5) ? 5 : pb);
    hlen  = 8 + ((ob > MAX_OFS) ? MAX_OFS : ob);
    noise = ($urandom_range(9) == 0);
    rs    = ($urandom_range(9) < 7);
    if (rs) gen_pos = 0;
    n = $urandom_range(20, 120);
    repeat (n) begin
      if (noise) begin
        b  = 8'($urandom);
        rs = ($urandom_range(19) == 0);
      end else begin
        if (!rs && $urandom_range(99) == 0) begin
          rs      = 1'b1;
          gen_pos = 0;
        end
        // follow the packet boundaries the block will see
        for (k = 0; k < 8; k++) begin
          if (gen_pos >= plen) gen_pos = 0;
          if (gen_pos == 0) begin
            seq     = ($urandom_range(9) == 0) ? 4'($urandom) : gen_seq;
            gen_seq = seq + 4'd1;
            gen_hdr = ((32'(seq) << 4 | 32'($urandom_range(15))) << (hlen - 8))
                      | (32'($urandom) & ((32'd1 << (hlen - 8)) - 1));
          end
          b[7-k] = (gen_pos < hlen) ? gen_hdr[hlen-1-gen_pos] : 1'($urandom);
          gen_pos++;
        end
      end
      push_byte(b, rs);
      rs = 1'b0;
      if ($urandom_range(299) == 0) drain();
    end
  endtask

  initial begin
    int phase;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_PACKET_BYTES;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.raw_byte = '0;
    in_if.restart  = 1'b0;
    idle_on        = 1'b1;
    sent           = 0;
    gen_pos        = 0;
    gen_hdr        = '0;
    gen_seq        = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset sizes: header of all ones, then all zeros after a restart
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hE0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h1F, 1'b0);

    // short packet, empty offset field, good then broken sequence
    drain();
    write_config(0, 0);
    push_byte(8'h1A, 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h2B, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h5C, 1'b0);

    // offset field wider than allowed, packet below the minimum
    drain();
    write_config(4, 31);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'hF0, 1'b0);

    phase = 0;
    while (sent < ITEM_TARGET) begin
      idle_on = (phase % 7) != 3;
      random_phase();
      phase++;
    end
    idle_on = 1'b1;

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
